>>> rtl/afts_pkg.sv
// Shared types and constants for the audio frame timestamp block.
// Used by the controller, the datapath and the top level.
package afts_pkg;

  localparam int NowW   = 63;
  localparam int CntW   = 48;
  localparam int RateW  = 20;
  localparam int FlenW  = 17;
  localparam int TolW   = 32;
  localparam int NsW    = 30;
  localparam int ProdW  = CntW + NsW;
  localparam int DivSteps = ProdW / 2;
  localparam int StepW  = $clog2(DivSteps);
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 63;

  localparam logic [NsW-1:0] NsPerSec = NsW'(1000000000);

  typedef enum logic [CfgIdxW-1:0] {
    REG_SAMPLING_RATE = 3'd0,
    REG_FRAME_LENGTH  = 3'd1,
    REG_TOLERANCE_NS  = 3'd2,
    REG_START_NS      = 3'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV,
    ST_SUM,
    ST_DRIFT,
    ST_CHECK,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic div_step;
    logic sum;
    logic drift;
    logic check;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
  } ctrl_sts_t;

endpackage

>>> rtl/afts_ctrl.sv
// Sequencer for the timestamp datapath and owner of the output valid flag.
// Depends on afts_pkg.
module afts_ctrl import afts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL_LO;
        end
      end
      ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_DRIFT;
      end
      ST_DRIFT: begin
        cmd_o.drift = 1'b1;
        state_d     = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = ST_FINISH;
      end
      ST_FINISH: begin
        // hold the result until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_rise_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("output valid rose outside of finish");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!out_valid_q || !out_stall_i))
    else $error("result written over a stalled item");
`endif

endmodule

>>> rtl/afts_dp.sv
// Datapath: sample count, count-to-ns multiply, radix-4 restoring divider,
// saturating sum, drift check and the output register. Depends on afts_pkg.
module afts_dp import afts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_cmd_t        cmd_i,
  output ctrl_sts_t        sts_o,
  input  logic [NowW-1:0]  now_ns_i,
  input  logic [RateW-1:0] rate_i,
  input  logic [FlenW-1:0] frame_len_i,
  input  logic [TolW-1:0]  tol_i,
  input  logic [NowW-1:0]  start_i,
  output logic [NowW-1:0]  stamp_ns_o,
  output logic             was_reset_o
);

  logic [CntW-1:0]  count_q, count_d;
  logic [NowW-1:0]  base_q, base_d;
  logic             primed_q, primed_d;
  logic [NowW-1:0]  now_q;
  logic [ProdW-1:0] dq_q, dq_d;
  logic [RateW-1:0] rem_q, rem_d;
  logic [StepW-1:0] step_q, step_d;
  logic [NowW-1:0]  stamp_q;
  logic signed [63:0] diff_q;
  logic             over_q;
  logic [NowW-1:0]  out_stamp_q;
  logic             out_reset_q;

  logic [2*NsW+1:0]     prod_lo;
  logic [CntW-32+NsW-1:0] prod_hi;
  logic [RateW:0]       r1, r2;
  logic [RateW-1:0]     r1s, r2s;
  logic                 ge1, ge2;
  logic [ProdW:0]       sum;
  logic signed [63:0]   tol_s;

  assign prod_lo = count_q[31:0] * NsPerSec;
  assign prod_hi = count_q[CntW-1:32] * NsPerSec;

  // two quotient bits per cycle; the remainder stays below the divisor
  always_comb begin
    r1  = {rem_q, dq_q[ProdW-1]};
    ge1 = (r1 >= {1'b0, rate_i});
    r1s = ge1 ? RateW'(r1 - {1'b0, rate_i}) : r1[RateW-1:0];
    r2  = {r1s, dq_q[ProdW-2]};
    ge2 = (r2 >= {1'b0, rate_i});
    r2s = ge2 ? RateW'(r2 - {1'b0, rate_i}) : r2[RateW-1:0];
  end

  assign sum   = {{(ProdW-NowW+1){1'b0}}, base_q} + {1'b0, dq_q};
  assign tol_s = $signed({32'b0, tol_i});

  always_comb begin
    count_d  = count_q;
    base_d   = base_q;
    primed_d = primed_q;
    dq_d     = dq_q;
    rem_d    = rem_q;
    step_d   = step_q;
    if (cmd_i.load) begin
      count_d = count_q + {{(CntW-FlenW){1'b0}}, frame_len_i};
      if (!primed_q) begin
        base_d   = start_i;
        primed_d = 1'b1;
      end
    end
    if (cmd_i.mul_lo) begin
      dq_d   = {{(ProdW-2*NsW-2){1'b0}}, prod_lo};
      rem_d  = '0;
      step_d = '0;
    end
    if (cmd_i.mul_hi) begin
      dq_d = dq_q + {prod_hi, 32'b0};
    end
    if (cmd_i.div_step) begin
      dq_d   = {dq_q[ProdW-3:0], ge1, ge2};
      rem_d  = r2s;
      step_d = step_q + 1'b1;
    end
    if (cmd_i.finish && over_q) begin
      base_d  = now_q;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      base_q   <= '0;
      primed_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      base_q   <= base_d;
      primed_q <= primed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q   <= dq_d;
    rem_q  <= rem_d;
    step_q <= step_d;
    if (cmd_i.load) begin
      now_q <= now_ns_i;
    end
    if (cmd_i.sum) begin
      // saturate to the largest 63-bit time
      stamp_q <= (|sum[ProdW:NowW]) ? '1 : sum[NowW-1:0];
    end
    if (cmd_i.drift) begin
      diff_q <= $signed({1'b0, now_q}) - $signed({1'b0, stamp_q});
    end
    if (cmd_i.check) begin
      over_q <= (diff_q > tol_s) || (diff_q < -tol_s);
    end
    if (cmd_i.finish) begin
      out_stamp_q <= over_q ? now_q : stamp_q;
      out_reset_q <= over_q;
    end
  end

  assign sts_o.div_last = (step_q == StepW'(DivSteps - 1));
  assign stamp_ns_o     = out_stamp_q;
  assign was_reset_o    = out_reset_q;

`ifndef SYNTHESIS
  a_rem_below_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < rate_i))
    else $error("divider remainder not below divisor");

  a_rebase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && over_q) |=> (base_q == out_stamp_q) && (count_q == '0))
    else $error("drift reset did not rebase the count");
`endif

endmodule

>>> rtl/audio_frame_timestamp_calc.sv
// Audio frame timestamp calculator: configuration registers, controller and
// datapath. Depends on afts_pkg, afts_ctrl and afts_dp.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / now_ns_i) takes one frame per
//   item with the clock time of its capture. Output channel (out_valid_o /
//   out_stall_i / stamp_ns_o / was_reset_o) returns one timestamp per frame.
//   Configuration writes (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i)
//   are always taken; index 0 sampling rate, 1 frame length, 2 tolerance,
//   3 start time; other indexes are ignored. Write them while idle.
//   The frame work is dominated by the 39-step radix-4 divider that turns
//   count * 1e9 into nanoseconds over the sampling rate.
//   The input stalls while a frame is in work; the result sits in an output
//   register, so a new frame is accepted while an old result waits. If the
//   receiver stalls, the finished frame holds in the last step until the
//   output register frees.
//   Reset clears the sample count and reloads the default registers; the
//   first frame after reset takes its base time from the start register.
module audio_frame_timestamp_calc import afts_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [NowW-1:0]     now_ns_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [NowW-1:0]     stamp_ns_o,
  output logic                was_reset_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [RateW-1:0] rate_reg_q;
  logic [FlenW-1:0] flen_q;
  logic [TolW-1:0]  tol_q;
  logic [NowW-1:0]  start_q;
  logic [RateW-1:0] rate;
  ctrl_cmd_t        cmd;
  ctrl_sts_t        sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_reg_q <= RateW'(16000);
      flen_q     <= FlenW'(1024);
      tol_q      <= TolW'(500000000);
      start_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_SAMPLING_RATE: rate_reg_q <= cfg_data_i[RateW-1:0];
        REG_FRAME_LENGTH:  flen_q     <= cfg_data_i[FlenW-1:0];
        REG_TOLERANCE_NS:  tol_q      <= cfg_data_i[TolW-1:0];
        REG_START_NS:      start_q    <= cfg_data_i[NowW-1:0];
        default: begin
        end
      endcase
    end
  end

  // treat a zero rate as one
  assign rate = (rate_reg_q == '0) ? RateW'(1) : rate_reg_q;

  afts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  afts_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .now_ns_i    (now_ns_i),
    .rate_i      (rate),
    .frame_len_i (flen_q),
    .tol_i       (tol_q),
    .start_i     (start_q),
    .stamp_ns_o  (stamp_ns_o),
    .was_reset_o (was_reset_o)
  );

endmodule
